// File: sv/assert_macros.svh
// Assertion macros used by the decoder top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/ucf_pkg.sv
// Types, constants and decode functions of the UTF-8 decoder with case folding
`timescale 1ns / 1ps
package ucf_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 21;
   localparam int LEN_W  = 3;
   localparam int BUF_W  = 32;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } ucf_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic done;
   } ucf_cmd_type;

   typedef struct packed {
      logic emit;
      logic last;
      logic out_free;
   } ucf_sts_type;

   typedef struct packed {
      logic             emit;
      logic [LEN_W-1:0] len;
      logic [CP_W-1:0]  cp;
   } ucf_eval_type;

   // sequence length announced by a lead byte
   function automatic logic [LEN_W-1:0] ucf_need(input logic [BYTE_W-1:0] b);
      logic [LEN_W-1:0] n;
      n = 3'd1;
      if (b < 8'h80) n = 3'd1;
      else if ((b & 8'hE0) == 8'hC0) n = 3'd2;
      else if ((b & 8'hF0) == 8'hE0) n = 3'd3;
      else if ((b & 8'hF8) == 8'hF0 && b <= 8'hF4) n = 3'd4;
      return n;
   endfunction

   // evaluate one scan position: win holds the bytes from the position on
   function automatic ucf_eval_type ucf_eval(input logic [BUF_W-1:0] win,
                                             input logic [LEN_W-1:0] avail,
                                             input logic last_byte);
      ucf_eval_type     r;
      logic [7:0]       b0, b1, b2, b3;
      logic [LEN_W-1:0] need, chk;
      logic             bad;
      b0   = win[7:0];
      b1   = win[15:8];
      b2   = win[23:16];
      b3   = win[31:24];
      need = ucf_need(b0);
      chk  = (avail < need) ? avail : need;
      bad  = (chk > 3'd1 && b1[7:6] != 2'b10) ||
             (chk > 3'd2 && b2[7:6] != 2'b10) ||
             (chk > 3'd3 && b3[7:6] != 2'b10);
      r.emit = 1'b0;
      r.len  = 3'd1;
      r.cp   = {13'd0, b0};
      if (avail == 3'd0) begin
         r.emit = 1'b0;
      end else if (need == 3'd1 || bad) begin
         r.emit = 1'b1;
      end else if (avail >= need) begin
         r.emit = 1'b1;
         r.len  = need;
         case (need)
            3'd2:    r.cp = {10'd0, b0[4:0], b1[5:0]};
            3'd3:    r.cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            3'd4:    r.cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: r.cp = {13'd0, b0};
         endcase
      end else if (last_byte) begin
         r.emit = 1'b1;
      end
      return r;
   endfunction

   // Latin and Cyrillic lower-case folding
   function automatic logic [CP_W-1:0] ucf_fold(input logic [CP_W-1:0] cp);
      logic [CP_W-1:0] r;
      r = cp;
      if (cp inside {[21'h41 : 21'h5A], [21'h410 : 21'h42F]}) r = cp + 21'd32;
      else if (cp == 21'h401) r = 21'h451;
      return r;
   endfunction

endpackage

// File: sv/ucf_req_if.sv
// Byte input channel of the UTF-8 decoder
`timescale 1ns / 1ps
interface ucf_req_if;
   logic                     valid;
   logic                     ready;
   logic [ucf_pkg::BYTE_W-1:0] data_byte;
   logic                     string_end;

   modport source (output valid, data_byte, string_end, input ready);
   modport sink   (input valid, data_byte, string_end, output ready);
endinterface

// File: sv/ucf_rsp_if.sv
// Code point output channel of the UTF-8 decoder
`timescale 1ns / 1ps
interface ucf_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [ucf_pkg::CP_W-1:0]  code_point;
   logic [ucf_pkg::LEN_W-1:0] byte_length;
   logic                      run_last;
   logic                      string_done;

   modport source (output valid, code_point, byte_length, run_last, string_done,
                   input ready);
   modport sink   (input valid, code_point, byte_length, run_last, string_done,
                   output ready);
endinterface

// File: sv/utf8_decode_casefold_core.sv
// Top level of the UTF-8 decoder with optional Latin/Cyrillic case folding
//
//   channel   dir   handshake      payload
//   req_ch    in    valid/ready    data_byte[7:0], string_end
//   rsp_ch    out   valid/ready    code_point[20:0], byte_length[2:0], run_last, string_done
//   csr_*     in    csr_wr_en      csr_wr_data (fold_enable)
//
// An item is accepted, then the scan steps through the byte window and emits one result
// (1 to 4) per step while rsp_ch has room, the last step also storing the rest back; an item
// that only extends a pending sequence is accepted, then stored back. Results leave through a
// single output register, so a stalled rsp_ch holds the scan. Reset is
// synchronous and clears the pending count, the controller and the output valid.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module utf8_decode_casefold_core (
   input  logic clock,
   input  logic reset,
   ucf_req_if.sink   req_ch,
   ucf_rsp_if.source rsp_ch,
   input  logic csr_wr_en,
   input  logic csr_wr_data
);
   import ucf_pkg::*;

   logic        fold_ff, fold_in;
   ucf_cmd_type cmd;
   ucf_sts_type sts;

   assign fold_in = csr_wr_en ? csr_wr_data : fold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ff <= 1'b0;
      end else begin
         fold_ff <= fold_in;
      end
   end

   ucf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ucf_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_ch.data_byte),
      .req_string_end  (req_ch.string_end),
      .fold_enable     (fold_ff),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_code_point  (rsp_ch.code_point),
      .rsp_byte_length (rsp_ch.byte_length),
      .rsp_run_last    (rsp_ch.run_last),
      .rsp_string_done (rsp_ch.string_done)
   );

   `ASSERT_NEXT(a_busy_after_load, clock, reset, cmd.load, !req_ch.ready, "ready after load")
   `ASSERT_SAME(a_step_needs_emit, clock, reset, cmd.step, sts.emit && sts.out_free, "bad step")
   `ASSERT_NEXT(a_step_fills_out, clock, reset, cmd.step, rsp_ch.valid, "step lost")
   `ASSERT_SAME(a_done_is_last, clock, reset, rsp_ch.valid && rsp_ch.string_done,
                rsp_ch.run_last, "string_done without run_last")

endmodule

// File: sv/ucf_ctrl.sv
// Controller of the UTF-8 decoder: accepts an item, then steps the scan
`timescale 1ns / 1ps
module ucf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ucf_pkg::ucf_sts_type sts,
   output ucf_pkg::ucf_cmd_type cmd
);
   import ucf_pkg::*;

   ucf_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!sts.emit) begin
               cmd.done = 1'b1;
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.step = 1'b1;
               if (sts.last) begin
                  cmd.done = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: sv/ucf_dp.sv
// Datapath of the UTF-8 decoder: byte window, scan position, output register
`timescale 1ns / 1ps
module ucf_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ucf_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                         req_string_end,
   input  logic                         fold_enable,
   input  ucf_pkg::ucf_cmd_type         cmd,
   output ucf_pkg::ucf_sts_type         sts,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ucf_pkg::CP_W-1:0]     rsp_code_point,
   output logic [ucf_pkg::LEN_W-1:0]    rsp_byte_length,
   output logic                         rsp_run_last,
   output logic                         rsp_string_done
);
   import ucf_pkg::*;

   logic [BUF_W-1:0] buf_ff, buf_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   logic             end_ff, end_in;
   logic             vld_ff, vld_in;
   logic [CP_W-1:0]  cp_ff, cp_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             last_ff, last_in;
   logic             done_ff, done_in;

   logic [LEN_W-1:0] n_cur, pos_nxt, start;
   logic [BUF_W-1:0] win0, win1, slot_mask, slot_data;
   ucf_eval_type     ev0, ev1;

   always_comb begin
      n_cur     = {1'b0, cnt_ff} + 3'd1;
      win0      = buf_ff >> {pos_ff, 3'b000};
      ev0       = ucf_eval(win0, n_cur - pos_ff, end_ff);
      pos_nxt   = pos_ff + ev0.len;
      win1      = buf_ff >> {pos_nxt, 3'b000};
      ev1       = ucf_eval(win1, n_cur - pos_nxt, end_ff);
      sts.emit  = ev0.emit;
      sts.last  = !ev1.emit;
      sts.out_free = !vld_ff || rsp_ready;
      slot_mask = 32'hFF << {cnt_ff, 3'b000};
      slot_data = {24'd0, req_data_byte} << {cnt_ff, 3'b000};
   end

   always_comb begin
      start   = cmd.step ? pos_nxt : pos_ff;
      buf_in  = buf_ff;
      cnt_in  = cnt_ff;
      pos_in  = pos_ff;
      end_in  = end_ff;
      vld_in  = vld_ff && !rsp_ready;
      cp_in   = cp_ff;
      len_in  = len_ff;
      last_in = last_ff;
      done_in = done_ff;
      if (cmd.load) begin
         buf_in = (buf_ff & ~slot_mask) | slot_data;
         pos_in = 3'd0;
         end_in = req_string_end;
      end
      if (cmd.step) begin
         vld_in  = 1'b1;
         cp_in   = fold_enable ? ucf_fold(ev0.cp) : ev0.cp;
         len_in  = ev0.len;
         last_in = !ev1.emit;
         done_in = !ev1.emit && end_ff;
         pos_in  = pos_nxt;
      end
      if (cmd.done) begin
         buf_in = buf_ff >> {start, 3'b000};
         cnt_in = 2'(n_cur - start);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff  <= buf_in;
      pos_ff  <= pos_in;
      end_ff  <= end_in;
      cp_ff   <= cp_in;
      len_ff  <= len_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp_valid       = vld_ff;
   assign rsp_code_point  = cp_ff;
   assign rsp_byte_length = len_ff;
   assign rsp_run_last    = last_ff;
   assign rsp_string_done = done_ff;

endmodule
